// File: sv/sacc_pkg.sv
// Shared types and constants for the set-associative cache tag controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package sacc_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_LOOK  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_status_t;

  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CONFLICT   = 2'd2;
  localparam logic [1:0] KIND_CAPACITY   = 2'd3;

  localparam logic [1:0] CFG_SETS_LOG2  = 2'd0;
  localparam logic [1:0] CFG_BLOCK_LOG2 = 2'd1;
  localparam logic [1:0] CFG_WAYS_LOG2  = 2'd2;
  localparam logic [1:0] CFG_POLICY     = 2'd3;

  localparam logic [3:0] RST_SETS_LOG2  = 4'd8;
  localparam logic [4:0] RST_BLOCK_LOG2 = 5'd2;
  localparam logic [1:0] RST_WAYS_LOG2  = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic [3:0] sets_log2;
    logic [4:0] block_log2;
    logic [1:0] ways_log2;
    logic [1:0] policy;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } line_t;

endpackage
`default_nettype wire

// File: sv/sacc_ctrl.sv
// Controller state machine: clearing sweep, accept, lookup and commit.
// Depends on sacc_pkg.
`default_nettype none
module sacc_ctrl
  import sacc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.clr_en = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_LOOK) && status.out_free;
  end

endmodule
`default_nettype wire

// File: sv/sacc_dp.sv
// Datapath: set-row memory, address split, way search, victim choice,
// statistic counters and the result register. Depends on sacc_pkg.
`default_nettype none
module sacc_dp
  import sacc_pkg::*;
#(
  parameter int SET_COUNT = 256,
  parameter int WAY_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic [31:0] in_raw_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [1:0]       out_miss_kind,
  output logic [2:0]       out_way_used,
  output logic [31:0]      out_access_count,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count,
  output logic [31:0]      out_compulsory_count,
  output logic [31:0]      out_conflict_count,
  output logic [31:0]      out_capacity_count
);

  localparam int SIW    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WIW    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int SL_MAX = $clog2(SET_COUNT + 1) - 1;
  localparam int WL_MAX = $clog2(WAY_COUNT + 1) - 1;
  localparam int FLW    = $clog2(SET_COUNT * WAY_COUNT) + 1;

  typedef line_t [WAY_COUNT-1:0] row_t;

  row_t mem [SET_COUNT];

  logic [SIW-1:0] clr_cnt_r;
  logic [SIW-1:0] set_r;
  logic [31:0]    tag_r;
  row_t           row_r;
  logic [FLW-1:0] filled_r;
  logic [15:0]    lfsr_r;
  logic [31:0]    acc_r, hits_r, miss_r, comp_r, conf_r, capa_r;
  logic           out_valid_r;

  // Effective geometry, saturated to what the arrays hold.
  logic [3:0]     sl;
  logic [2:0]     wl;
  logic [SIW-1:0] set_mask;
  logic [WIW-1:0] way_mask;
  logic [31:0]    addr, blk;

  always_comb begin
    sl = (int'(cfg.sets_log2) > SL_MAX) ? 4'(SL_MAX) : cfg.sets_log2;
    wl = (int'(cfg.ways_log2) > WL_MAX) ? 3'(WL_MAX) : {1'b0, cfg.ways_log2};
    set_mask = SIW'(((SIW+1)'(1) << sl) - (SIW+1)'(1));
    way_mask = WIW'(((WIW+1)'(1) << wl) - (WIW+1)'(1));
    addr = {in_raw_word[7:0], in_raw_word[15:8], in_raw_word[23:16], in_raw_word[31:24]};
    blk  = addr >> cfg.block_log2;
  end

  // Lookup over the row that was read on the accepted beat.
  logic           hit, has_free;
  logic [WIW-1:0] hit_way, free_way, old_way, rnd_way, way_sel;
  logic [31:0]    min_stamp, stamp_new;
  logic [15:0]    lfsr_nxt;
  logic [1:0]     kind;
  logic [FLW-1:0] lines_in_use;
  logic           write_row;
  row_t           row_nxt;

  always_comb begin
    hit       = 1'b0;
    has_free  = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    old_way   = '0;
    min_stamp = row_r[0].stamp;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if ((WIW'(i) & ~way_mask) == '0) begin
        if (!hit && row_r[i].valid && row_r[i].tag == tag_r) begin
          hit     = 1'b1;
          hit_way = WIW'(i);
        end
        if (!has_free && !row_r[i].valid) begin
          has_free = 1'b1;
          free_way = WIW'(i);
        end
        if (i > 0 && row_r[i].stamp < min_stamp) begin
          min_stamp = row_r[i].stamp;
          old_way   = WIW'(i);
        end
      end
    end

    lfsr_nxt = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 16'h0000);
    rnd_way  = WIW'(lfsr_nxt) & way_mask;

    lines_in_use = FLW'(1) << (sl + 4'(wl));
    stamp_new    = acc_r + 32'd1;

    priority if (hit) begin
      kind    = KIND_NONE;
      way_sel = hit_way;
    end else if (has_free) begin
      kind    = KIND_COMPULSORY;
      way_sel = free_way;
    end else begin
      kind    = (filled_r < lines_in_use) ? KIND_CONFLICT : KIND_CAPACITY;
      way_sel = (cfg.policy == POL_RANDOM) ? rnd_way : old_way;
    end

    write_row = !hit || (cfg.policy == POL_LRU);
    row_nxt   = row_r;
    row_nxt[way_sel].stamp = stamp_new;
    if (!hit) begin
      row_nxt[way_sel].valid = 1'b1;
      row_nxt[way_sel].tag   = tag_r;
    end
  end

  // Set-row memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && write_row) begin
      mem[set_r] <= row_nxt;
    end
    if (cmd.load) begin
      row_r <= mem[blk[SIW-1:0] & set_mask];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r <= blk[SIW-1:0] & set_mask;
      tag_r <= blk >> sl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      filled_r    <= '0;
      lfsr_r      <= LFSR_SEED;
      acc_r       <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      comp_r      <= '0;
      conf_r      <= '0;
      capa_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + SIW'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        acc_r <= stamp_new;
        if (hit) begin
          hits_r <= hits_r + 32'd1;
        end else begin
          miss_r <= miss_r + 32'd1;
        end
        if (kind == KIND_COMPULSORY) begin
          comp_r   <= comp_r + 32'd1;
          filled_r <= filled_r + FLW'(1);
        end
        if (kind == KIND_CONFLICT) conf_r <= conf_r + 32'd1;
        if (kind == KIND_CAPACITY) capa_r <= capa_r + 32'd1;
        if (!hit && !has_free && cfg.policy == POL_RANDOM) begin
          lfsr_r <= lfsr_nxt;
        end
      end
    end
  end

  // Result register; the counters above already hold the values after this beat.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit       <= hit;
      out_miss_kind <= kind;
      out_way_used  <= 3'(way_sel);
    end
  end

  always_comb begin
    out_valid            = out_valid_r;
    out_access_count     = acc_r;
    out_hit_count        = hits_r;
    out_miss_count       = miss_r;
    out_compulsory_count = comp_r;
    out_conflict_count   = conf_r;
    out_capacity_count   = capa_r;
    status.clr_last      = (clr_cnt_r == SIW'(SET_COUNT - 1));
    status.out_free      = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// File: sv/set_assoc_cache_tag_controller_unit.sv
// Set-associative cache tag controller, top level with configuration registers.
// Each access reads the set row from the tag memory on the accepted beat; the
// commit loads the result and writes the row back, except on a non-LRU hit.
// Commit waits for a free result register; the next beat is accepted after it.
// After reset a clearing pass writes SET_COUNT rows, one per cycle, before the
// first beat is accepted; configuration writes are taken throughout.
`default_nettype none
module set_assoc_cache_tag_controller_unit
  import sacc_pkg::*;
#(
  parameter int SET_COUNT = 256,
  parameter int WAY_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_raw_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [1:0]       out_miss_kind,
  output logic [2:0]       out_way_used,
  output logic [31:0]      out_access_count,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count,
  output logic [31:0]      out_compulsory_count,
  output logic [31:0]      out_conflict_count,
  output logic [31:0]      out_capacity_count
);

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sets_log2  <= RST_SETS_LOG2;
      cfg_r.block_log2 <= RST_BLOCK_LOG2;
      cfg_r.ways_log2  <= RST_WAYS_LOG2;
      cfg_r.policy     <= POL_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETS_LOG2:  cfg_r.sets_log2  <= cfg_data[3:0];
        CFG_BLOCK_LOG2: cfg_r.block_log2 <= cfg_data;
        CFG_WAYS_LOG2:  cfg_r.ways_log2  <= cfg_data[1:0];
        CFG_POLICY:     cfg_r.policy     <= cfg_data[1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  sacc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sacc_dp #(
    .SET_COUNT (SET_COUNT),
    .WAY_COUNT (WAY_COUNT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .cmd                  (cmd),
    .status               (status),
    .in_raw_word          (in_raw_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_miss_kind        (out_miss_kind),
    .out_way_used         (out_way_used),
    .out_access_count     (out_access_count),
    .out_hit_count        (out_hit_count),
    .out_miss_count       (out_miss_count),
    .out_compulsory_count (out_compulsory_count),
    .out_conflict_count   (out_conflict_count),
    .out_capacity_count   (out_capacity_count)
  );

endmodule
`default_nettype wire

// File: dv/tb_set_assoc_cache_tag_controller_unit.sv
// Self-checking testbench for the set-associative cache tag controller unit.
// Predicts hit, miss kind, way and the statistic counters for every access.
// Depends on sacc_pkg and set_assoc_cache_tag_controller_unit.
`default_nettype none
module tb_set_assoc_cache_tag_controller_unit;
  import sacc_pkg::*;

  localparam int NSET = 256;
  localparam int NWAY = 8;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic        hit;
    logic [1:0]  kind;
    logic [2:0]  way;
    logic [31:0] acc, hits, miss, comp, conf, cap;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SETS_LOG2;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_raw_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [1:0] out_miss_kind;
  logic [2:0] out_way_used;
  logic [31:0] out_access_count, out_hit_count, out_miss_count;
  logic [31:0] out_compulsory_count, out_conflict_count, out_capacity_count;

  always #2 clk = ~clk;

  set_assoc_cache_tag_controller_unit dut (.*);

  // Predictor state.
  logic        tv_valid [NSET*NWAY];
  logic [31:0] tv_tag   [NSET*NWAY];
  logic [31:0] tv_stamp [NSET*NWAY];
  logic [31:0] n_acc, n_hit, n_miss, n_comp, n_conf, n_cap;
  logic [11:0] n_filled;
  logic [15:0] victim_rng;
  logic [3:0]  c_sets;
  logic [4:0]  c_block;
  logic [1:0]  c_ways;
  logic [1:0]  c_policy;

  logic [31:0] word_queue[$];
  access_result_t expected_results[$];
  int errors = 0;
  int mismatches = 0;
  bit quiet_tail = 1'b0;
  bit hold_sender = 1'b0;
  int long_hold = 0;
  int idle_cycles = 0;

  function automatic void predict_access(input logic [31:0] raw);
    int sl, wl, nsets, nways, base, way, i;
    logic [63:0] addr, blk;
    logic [31:0] tag;
    bit hit, has_free;
    logic [1:0] kind;
    access_result_t r;
    sl = (c_sets > 8) ? 8 : c_sets;
    wl = (c_ways > 3) ? 3 : c_ways;
    nsets = 1 << sl;
    nways = 1 << wl;
    addr = {32'd0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    blk = addr >> c_block;
    tag = 32'(blk >> sl);
    base = int'(blk & 64'(nsets - 1)) * NWAY;
    way = 0;
    hit = 0;
    has_free = 0;
    kind = KIND_NONE;
    n_acc++;
    for (i = 0; i < nways; i++)
      if (!hit && tv_valid[base+i] && tv_tag[base+i] == tag) begin
        hit = 1;
        way = i;
      end
    if (hit) begin
      n_hit++;
      if (c_policy == POL_LRU) tv_stamp[base+way] = n_acc;
    end else begin
      n_miss++;
      for (i = 0; i < nways; i++)
        if (!has_free && !tv_valid[base+i]) begin
          has_free = 1;
          way = i;
        end
      if (has_free) begin
        kind = KIND_COMPULSORY;
        n_comp++;
      end else if (n_filled < nsets * nways) begin
        kind = KIND_CONFLICT;
        n_conf++;
      end else begin
        kind = KIND_CAPACITY;
        n_cap++;
      end
      if (!has_free) begin
        if (c_policy == POL_RANDOM) begin
          victim_rng = victim_rng[0] ? ((victim_rng >> 1) ^ LFSR_TAPS) : (victim_rng >> 1);
          way = int'(victim_rng) & (nways - 1);
        end else begin
          way = 0;
          for (i = 1; i < nways; i++)
            if (tv_stamp[base+i] < tv_stamp[base+way]) way = i;
        end
      end
      if (!tv_valid[base+way]) n_filled++;
      tv_valid[base+way] = 1;
      tv_tag[base+way] = tag;
      tv_stamp[base+way] = n_acc;
    end
    r.hit = hit;
    r.kind = kind;
    r.way = 3'(way);
    r.acc = n_acc;
    r.hits = n_hit;
    r.miss = n_miss;
    r.comp = n_comp;
    r.conf = n_conf;
    r.cap = n_cap;
    expected_results.push_back(r);
  endfunction

  // Driver: bursts of idling, none in the quiet tail.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_access(in_raw_word);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (word_queue.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_raw_word <= word_queue.pop_front();
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  int recv_gap = 0;
  always @(posedge clk) begin
    access_result_t e, a;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        a = {out_hit, out_miss_kind, out_way_used, out_access_count, out_hit_count,
             out_miss_count, out_compulsory_count, out_conflict_count, out_capacity_count};
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result beat %h", a);
        end else begin
          e = expected_results.pop_front();
          if (a !== e) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp hit=%0d kind=%0d way=%0d cnt=%0d/%0d/%0d/%0d/%0d/%0d, %s",
                       e.hit, e.kind, e.way, e.acc, e.hits, e.miss, e.comp, e.conf, e.cap,
                       $sformatf("got hit=%0d kind=%0d way=%0d cnt=%0d/%0d/%0d/%0d/%0d/%0d",
                       a.hit, a.kind, a.way, a.acc, a.hits, a.miss, a.comp, a.conf, a.cap));
          end
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (word_queue.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SETS_LOG2:  c_sets = val[3:0];
      CFG_BLOCK_LOG2: c_block = val;
      CFG_WAYS_LOG2:  c_ways = val[1:0];
      default:        c_policy = val[1:0];
    endcase
  endtask

  task automatic set_geometry(input int s, input int b, input int w, input int p);
    write_reg(CFG_SETS_LOG2, 5'(s));
    write_reg(CFG_BLOCK_LOG2, 5'(b));
    write_reg(CFG_WAYS_LOG2, 5'(w));
    write_reg(CFG_POLICY, 5'(p));
  endtask

  // Raw word for an address: bytes reversed.
  function automatic logic [31:0] raw_of(input logic [31:0] addr);
    return {addr[7:0], addr[15:8], addr[23:16], addr[31:24]};
  endfunction

  // Well-formed traffic: addresses drawn from a small pool so sets refill and hit.
  task automatic queue_pool_traffic(input int count, input int pool);
    logic [31:0] base_addr [16];
    int i;
    for (i = 0; i < 16; i++) base_addr[i] = $urandom();
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) word_queue.push_back($urandom());
      else word_queue.push_back(raw_of(base_addr[$urandom_range(0, pool - 1)] ^
                                       ($urandom_range(0, 3) << 12)));
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NSET*NWAY; i++) begin
      tv_valid[i] = 0;
      tv_tag[i] = 0;
      tv_stamp[i] = 0;
    end
    {n_acc, n_hit, n_miss, n_comp, n_conf, n_cap} = '0;
    n_filled = '0;
    victim_rng = LFSR_SEED;
    c_sets = RST_SETS_LOG2;
    c_block = RST_BLOCK_LOG2;
    c_ways = RST_WAYS_LOG2;
    c_policy = POL_LRU;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, reset geometry, repeated hit.
    word_queue.push_back(32'h0000_0000);
    word_queue.push_back(32'hFFFF_FFFF);
    word_queue.push_back(32'h0000_0000);
    word_queue.push_back(32'hA5A5_5A5A);
    word_queue.push_back(32'h5A5A_A5A5);
    wait_drained();

    // One set, one way, tiny block: capacity misses at once; oversize fields saturate.
    set_geometry(0, 0, 0, POL_FIFO);
    for (i = 0; i < 4; i++) word_queue.push_back(raw_of(32'(i)));
    wait_drained();
    set_geometry(15, 31, 3, POL_RANDOM);
    for (i = 0; i < 4; i++) word_queue.push_back($urandom());
    wait_drained();
    // Policy three behaves as oldest-stamp without refresh.
    set_geometry(1, 4, 1, 3);
    for (i = 0; i < 8; i++) word_queue.push_back(raw_of(32'(i) << 5));
    wait_drained();

    // Random phases over several geometries and policies.
    for (i = 0; i < 8; i++) begin
      set_geometry($urandom_range(0, 9), $urandom_range(0, 31), $urandom_range(0, 3),
                   $urandom_range(0, 3));
      if (i == 3) begin
        long_hold = 300;
        queue_pool_traffic(60, 8);
      end else begin
        queue_pool_traffic(70, $urandom_range(1, 16));
      end
      if (i == 5) begin
        while (word_queue.size() > 35) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    set_geometry(8, 2, 3, POL_LRU);
    quiet_tail = 1'b1;
    queue_pool_traffic(80, 16);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
